### rtl/facr_pkg.sv
// Shared types and codes for the fully associative cache replacement core.
`timescale 1ns / 1ps
`default_nettype none

package facr_pkg;

    // Widths fixed by the register map and the result fields
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int WAYS_W      = 6;
    localparam int MEMB_W      = 8;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_BLOCKS  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE_ERR = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SIZE_ERR  = 2'd2;

    // Item kinds and policies
    localparam logic KIND_REFERENCE = 1'b0;
    localparam logic KIND_RESTART   = 1'b1;
    localparam logic POLICY_FIFO    = 1'b0;
    localparam logic POLICY_LRU     = 1'b1;

    // Reset values of the registers
    localparam logic [WAYS_W-1:0] WAYS_RESET = 6'd4;
    localparam logic [MEMB_W-1:0] MEMB_RESET = 8'd32;

    // Legal memory sizes
    localparam logic [MEMB_W-1:0] MEMB_32  = 8'd32;
    localparam logic [MEMB_W-1:0] MEMB_64  = 8'd64;
    localparam logic [MEMB_W-1:0] MEMB_128 = 8'd128;

    // Control broadcast to every cell of the entry chain
    typedef struct packed {
        logic flush;      // drop every entry
        logic load_miss;  // miss: every in-use cell takes its neighbour's entry
        logic load_hit;   // LRU hit: cells up to the hit take their neighbour's entry
    } facr_cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/fully_assoc_cache_replacement_core.sv
// Top level: fully associative cache with FIFO or LRU replacement and hit counts.
//
// Usage
//   Command channel: an item (kind, block_number) is taken at a rising edge with
//   start high and busy low. busy stays low, so one item can be taken every cycle.
//   Result channel: hit, status, hit_count and reference_count appear in the cycle
//   after the item is taken, for exactly one cycle, marked by done. There is no
//   back-pressure; the receiver must capture the beat when done is high.
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data. cfg_ready is
//   always high. Writing ways_in_use or mem_blocks empties the cache; writing
//   policy_mode keeps the entries. Write only while no result is outstanding.
// Timing
//   One item per cycle. The lookup is a row of MAX_WAYS cells comparing in
//   parallel; the match flag ripples along the row in the same cycle, and on a
//   miss every in-use cell, on an LRU hit every cell up to the hit, shifts one place.
// Reset
//   All entries invalid, counts zero, policy FIFO, 4 ways in use, 32 blocks.
//   A restart item does the same to entries and counts, keeping the registers.
`timescale 1ns / 1ps
`default_nettype none

module fully_assoc_cache_replacement_core
    import facr_pkg::*;
#(
    parameter int MAX_WAYS   = 32,
    parameter int BLOCK_BITS = 7,
    parameter int COUNT_BITS = 16
)
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire                          kind,
    input  wire  [BLOCK_BITS-1:0]        block_number,
    output logic                         done,
    output logic                         hit,
    output logic [STATUS_W-1:0]          status,
    output logic [COUNT_OUT_W-1:0]       hit_count,
    output logic [COUNT_OUT_W-1:0]       reference_count,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire  [CFG_IDX_W-1:0]         cfg_index,
    input  wire  [CFG_DATA_W-1:0]        cfg_data
);

    localparam int CMP_W = (BLOCK_BITS > MEMB_W) ? BLOCK_BITS : MEMB_W;
    localparam logic [WAYS_W:0] MAX_WAYS_W = (WAYS_W + 1)'(MAX_WAYS);

    // Configuration
    logic                  policy_reg;
    logic                  policy_next;
    logic [WAYS_W-1:0]     ways_reg;
    logic [WAYS_W-1:0]     ways_next;
    logic [MEMB_W-1:0]     memb_reg;
    logic [MEMB_W-1:0]     memb_next;
    logic                  cfg_we;
    logic                  cfg_resize;

    // Counters and result
    logic [COUNT_BITS-1:0] hits_reg;
    logic [COUNT_BITS-1:0] hits_next;
    logic [COUNT_BITS-1:0] refs_reg;
    logic [COUNT_BITS-1:0] refs_next;
    logic                  done_reg;
    logic                  done_next;
    logic                  hit_reg;
    logic                  hit_next;
    logic [STATUS_W-1:0]   status_reg;
    logic [STATUS_W-1:0]   status_next;

    // Lookup
    logic                  accept;
    logic                  restart;
    logic                  sizes_ok;
    logic                  block_ok;
    logic                  ref_go;
    logic                  lookup_hit;
    facr_cell_ctrl_t       cell_ctrl;

    logic                  cell_valid [MAX_WAYS];
    logic [BLOCK_BITS-1:0] cell_block [MAX_WAYS];
    logic                  match_chain [MAX_WAYS+1];

    assign accept     = start && !busy;
    assign restart    = accept && (kind == KIND_RESTART);
    assign cfg_we     = cfg_valid && cfg_ready;
    assign cfg_resize = cfg_we && ((cfg_index == CFG_WAYS_IN_USE) ||
                                   (cfg_index == CFG_MEM_BLOCKS));

    assign sizes_ok = ((memb_reg == MEMB_32) || (memb_reg == MEMB_64) ||
                       (memb_reg == MEMB_128)) &&
                      (ways_reg != '0) &&
                      (ways_reg <= memb_reg[MEMB_W-1:2]) &&
                      ({1'b0, ways_reg} <= MAX_WAYS_W);

    assign block_ok = CMP_W'(block_number) < CMP_W'(memb_reg);
    assign ref_go   = accept && (kind == KIND_REFERENCE) && sizes_ok && block_ok;

    assign lookup_hit = match_chain[0];

    always_comb
    begin
        cell_ctrl.flush     = restart || cfg_resize;
        cell_ctrl.load_miss = ref_go && !lookup_hit;
        cell_ctrl.load_hit  = ref_go && lookup_hit && (policy_reg == POLICY_LRU);
    end

    assign match_chain[MAX_WAYS] = 1'b0;

    // Entry chain: position 0 is the newest / most recently used
    for (genvar k = 0; k < MAX_WAYS; k++)
    begin : g_cell
        logic                  prev_valid;
        logic [BLOCK_BITS-1:0] prev_block;

        if (k == 0)
        begin : g_head
            assign prev_valid = 1'b1;
            assign prev_block = block_number;
        end
        else
        begin : g_body
            assign prev_valid = cell_valid[k-1];
            assign prev_block = cell_block[k-1];
        end

        facr_cell #(
            .IDX        (k),
            .BLOCK_BITS (BLOCK_BITS)
        ) u_cell (
            .clk                 (clk),
            .rst_n               (rst_n),
            .ctrl                (cell_ctrl),
            .ways_in_use         (ways_reg),
            .lookup_block        (block_number),
            .prev_valid          (prev_valid),
            .prev_block          (prev_block),
            .match_above         (match_chain[k+1]),
            .entry_valid         (cell_valid[k]),
            .entry_block         (cell_block[k]),
            .match_here_or_above (match_chain[k])
        );
    end

    // Configuration registers
    always_comb
    begin
        policy_next = policy_reg;
        ways_next   = ways_reg;
        memb_next   = memb_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POLICY_MODE: policy_next = cfg_data[0];
                CFG_WAYS_IN_USE: ways_next   = cfg_data[WAYS_W-1:0];
                CFG_MEM_BLOCKS:  memb_next   = cfg_data;
                default:         ;
            endcase
        end
    end

    // Counters and result beat
    always_comb
    begin
        hits_next   = hits_reg;
        refs_next   = refs_reg;
        hit_next    = 1'b0;
        status_next = STATUS_OK;
        done_next   = accept;
        priority if (restart)
        begin
            hits_next = '0;
            refs_next = '0;
        end
        else if (accept && !sizes_ok)
        begin
            status_next = STATUS_SIZE_ERR;
        end
        else if (accept && !block_ok)
        begin
            status_next = STATUS_RANGE_ERR;
        end
        else if (ref_go)
        begin
            refs_next = (refs_reg == '1) ? refs_reg : refs_reg + 1'b1;
            if (lookup_hit)
            begin
                hit_next  = 1'b1;
                hits_next = (hits_reg == '1) ? hits_reg : hits_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POLICY_FIFO;
            ways_reg   <= WAYS_RESET;
            memb_reg   <= MEMB_RESET;
            hits_reg   <= '0;
            refs_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            policy_reg <= policy_next;
            ways_reg   <= ways_next;
            memb_reg   <= memb_next;
            hits_reg   <= hits_next;
            refs_reg   <= refs_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg    <= hit_next;
        status_reg <= status_next;
    end

    assign busy            = 1'b0;
    assign cfg_ready       = 1'b1;
    assign done            = done_reg;
    assign hit             = hit_reg;
    assign status          = status_reg;
    assign hit_count       = COUNT_OUT_W'(hits_reg);
    assign reference_count = COUNT_OUT_W'(refs_reg);

    // Every taken item yields exactly one beat on the next cycle
    a_beat_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("taken item produced no result beat");

    // A hit is only ever reported on a good reference
    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> (status == STATUS_OK))
        else $error("hit reported with error status");

    // Hits can never outrun references
    a_hits_le_refs: assert property (@(posedge clk) disable iff (!rst_n)
        hits_reg <= refs_reg)
        else $error("hit count exceeds reference count");

    // A restart beat carries cleared counts
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(start && !busy && (kind == KIND_RESTART)))
            |-> ((hit_count == '0) && (reference_count == '0) && !hit))
        else $error("restart did not clear the counts");

endmodule

`default_nettype wire

### rtl/facr_cell.sv
// One cache entry of the age-ordered chain: holds, compares and shifts.
`timescale 1ns / 1ps
`default_nettype none

module facr_cell
    import facr_pkg::*;
#(
    parameter int IDX        = 0,
    parameter int BLOCK_BITS = 7
)
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire facr_cell_ctrl_t         ctrl,
    input  wire  [WAYS_W-1:0]            ways_in_use,
    input  wire  [BLOCK_BITS-1:0]        lookup_block,
    input  wire                          prev_valid,
    input  wire  [BLOCK_BITS-1:0]        prev_block,
    input  wire                          match_above,
    output logic                         entry_valid,
    output logic [BLOCK_BITS-1:0]        entry_block,
    output logic                         match_here_or_above
);

    localparam logic [WAYS_W:0] IDX_W = (WAYS_W + 1)'(IDX);

    logic                  valid_reg;
    logic                  valid_next;
    logic [BLOCK_BITS-1:0] block_reg;
    logic [BLOCK_BITS-1:0] block_next;
    logic                  in_use;
    logic                  match;
    logic                  load;

    assign in_use = {1'b0, ways_in_use} > IDX_W;
    assign match  = in_use && valid_reg && (block_reg == lookup_block);

    // Runs from the far end towards position 0: set if the hit sits here or further out
    assign match_here_or_above = match_above || match;

    assign load = (ctrl.load_miss && in_use) || (ctrl.load_hit && match_here_or_above);

    always_comb
    begin
        valid_next = valid_reg;
        block_next = block_reg;
        if (ctrl.flush)
        begin
            valid_next = 1'b0;
        end
        else if (load)
        begin
            valid_next = prev_valid;
            block_next = prev_block;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        block_reg <= block_next;
    end

    assign entry_valid = valid_reg;
    assign entry_block = block_reg;

endmodule

`default_nettype wire

### tb/fully_assoc_cache_replacement_core_test.sv
// Testbench for the fully associative cache core: directed and random beats checked against a cache model.
`timescale 1ns / 1ps

module fully_assoc_cache_replacement_core_test;
    import facr_pkg::*;

    localparam int CACHE_WAYS = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic       kind;
        logic [6:0] blk;
    } ref_item_t;

    typedef struct packed {
        logic                   hit;
        logic [STATUS_W-1:0]    status;
        logic [COUNT_OUT_W-1:0] hit_count;
        logic [COUNT_OUT_W-1:0] reference_count;
    } access_outcome_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   kind = KIND_REFERENCE;
    logic [6:0]             block_number = '0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = CFG_POLICY_MODE;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    wire                    busy;
    wire                    done;
    wire                    hit;
    wire [STATUS_W-1:0]     status;
    wire [COUNT_OUT_W-1:0]  hit_count;
    wire [COUNT_OUT_W-1:0]  reference_count;
    wire                    cfg_ready;

    fully_assoc_cache_replacement_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .kind            (kind),
        .block_number    (block_number),
        .done            (done),
        .hit             (hit),
        .status          (status),
        .hit_count       (hit_count),
        .reference_count (reference_count),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // Cache model: position 0 is newest / most recently used
    logic                   line_ok [CACHE_WAYS];
    logic [6:0]             line_blk [CACHE_WAYS];
    logic [COUNT_OUT_W-1:0] hits_total;
    logic [COUNT_OUT_W-1:0] refs_total;
    logic                   policy;
    logic [WAYS_W-1:0]      ways;
    logic [MEMB_W-1:0]      memb;

    ref_item_t       pending_items [$];
    access_outcome_t due_outcomes [$];
    ref_item_t       next_item;
    access_outcome_t seen;
    access_outcome_t want;
    bit              hold_off;
    bit              steady_run = 1'b0;
    int              fail_count = 0;

    function automatic void empty_entries();
        for (int i = 0; i < CACHE_WAYS; i++)
        begin
            line_ok[i] = 1'b0;
            line_blk[i] = '0;
        end
    endfunction

    function automatic void promote(input int pos, input logic [6:0] b);
        for (int k = pos; k > 0; k--)
        begin
            line_ok[k] = line_ok[k-1];
            line_blk[k] = line_blk[k-1];
        end
        line_ok[0] = 1'b1;
        line_blk[0] = b;
    endfunction

    function automatic void cache_access(input logic k, input logic [6:0] b);
        access_outcome_t o;
        int              n;
        int              slot;
        o.hit = 1'b0;
        o.status = STATUS_OK;
        n = ways;
        if (k == KIND_RESTART)
        begin
            empty_entries();
            hits_total = '0;
            refs_total = '0;
        end
        else if (!(memb == MEMB_32 || memb == MEMB_64 || memb == MEMB_128) || ways == 0
                 || ways > (memb >> 2) || ways > CACHE_WAYS)
            o.status = STATUS_SIZE_ERR;
        else if (b >= memb)
            o.status = STATUS_RANGE_ERR;
        else
        begin
            slot = n;
            for (int i = 0; i < n; i++)
                if (slot == n && line_ok[i] && line_blk[i] == b)
                    slot = i;
            if (refs_total != '1)
                refs_total = refs_total + 1'b1;
            if (slot < n)
            begin
                o.hit = 1'b1;
                if (hits_total != '1)
                    hits_total = hits_total + 1'b1;
                if (policy == POLICY_LRU)
                    promote(slot, b);
            end
            else
                promote(n - 1, b);
        end
        o.hit_count = hits_total;
        o.reference_count = refs_total;
        due_outcomes.push_back(o);
    endfunction

    function automatic void flag_error(input string what, input access_outcome_t w,
                                       input access_outcome_t g);
        fail_count++;
        if (fail_count <= 10)
            $display({"%0t: %s: want hit=%0d status=%0d hits=%0d refs=%0d,",
                      " got hit=%0d status=%0d hits=%0d refs=%0d"},
                     $realtime, what, w.hit, w.status, w.hit_count, w.reference_count,
                     g.hit, g.status, g.hit_count, g.reference_count);
    endfunction

    function automatic void add_item(input logic k, input logic [6:0] b);
        ref_item_t it;
        it.kind = k;
        it.blk = b;
        pending_items.push_back(it);
    endfunction

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Command driver: one beat per accepted start
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            kind <= KIND_REFERENCE;
            block_number <= '0;
        end
        else
        begin
            if (start && !busy)
                cache_access(kind, block_number);
            if (!start || !busy)
            begin
                hold_off = !steady_run && ($urandom_range(99) < 14);
                if (pending_items.size() != 0 && !hold_off)
                begin
                    next_item = pending_items.pop_front();
                    start <= 1'b1;
                    kind <= next_item.kind;
                    block_number <= next_item.blk;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Result monitor: no back-pressure, every done beat is taken
    always @(posedge clk)
    begin
        if (done)
        begin
            seen.hit = hit;
            seen.status = status;
            seen.hit_count = hit_count;
            seen.reference_count = reference_count;
            if (due_outcomes.size() == 0)
                flag_error("result beat with nothing outstanding", seen, seen);
            else
            begin
                want = due_outcomes.pop_front();
                if (seen.hit !== want.hit || seen.status !== want.status
                    || seen.hit_count !== want.hit_count
                    || seen.reference_count !== want.reference_count)
                    flag_error("result mismatch", want, seen);
            end
        end
    end

    task automatic settle();
        while (pending_items.size() != 0 || start || due_outcomes.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_POLICY_MODE: policy = data[0];
            CFG_WAYS_IN_USE:
            begin
                ways = data[WAYS_W-1:0];
                empty_entries();
            end
            CFG_MEM_BLOCKS:
            begin
                memb = data;
                empty_entries();
            end
            default: ;
        endcase
    endtask

    task automatic random_setup(input bit legal);
        logic [7:0] m_data;
        logic [7:0] w_data;
        logic [7:0] p_data;
        logic [5:0] w;
        int         top;
        case ($urandom_range(2))
            0: m_data = MEMB_32;
            1: m_data = MEMB_64;
            default: m_data = MEMB_128;
        endcase
        top = m_data / 4;
        if (top > CACHE_WAYS)
            top = CACHE_WAYS;
        case ($urandom_range(3))
            0: w = 6'd1;
            1: w = 6'(top);
            default: w = 6'($urandom_range(top, 1));
        endcase
        if (!legal)
        begin
            case ($urandom_range(2))
                0:
                begin
                    m_data = 8'($urandom_range(255));
                    if (m_data == MEMB_32 || m_data == MEMB_64 || m_data == MEMB_128)
                        m_data = m_data + 8'd1;
                end
                1: w = 6'd0;
                default: w = 6'($urandom_range(63, top + 1));
            endcase
        end
        w_data = 8'($urandom_range(255));
        w_data[5:0] = w;
        p_data = 8'($urandom_range(255));
        write_reg(CFG_MEM_BLOCKS, m_data);
        write_reg(CFG_WAYS_IN_USE, w_data);
        write_reg(CFG_POLICY_MODE, p_data);
    endtask

    // Mostly references into a working set a little larger than the cache
    task automatic queue_references(input int count);
        int         lim;
        int         span;
        int         base;
        int         r;
        logic [6:0] b;
        lim = (memb == MEMB_32 || memb == MEMB_64 || memb == MEMB_128) ? memb : 128;
        span = (ways == 0 ? 4 : ways) + $urandom_range(3);
        base = $urandom_range(lim - 1);
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 2)
                add_item(KIND_RESTART, 7'($urandom_range(127)));
            else if (r < 8)
                add_item(KIND_REFERENCE, 7'($urandom_range(127)));
            else
            begin
                b = 7'((base + $urandom_range(span - 1)) % lim);
                add_item(KIND_REFERENCE, b);
            end
        end
    endtask

    initial
    begin
        bit legal;
        empty_entries();
        hits_total = '0;
        refs_total = '0;
        policy = POLICY_FIFO;
        ways = WAYS_RESET;
        memb = MEMB_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // FIFO at reset sizes: range edges, fill, evict, restart
        add_item(KIND_REFERENCE, 7'd0);
        add_item(KIND_REFERENCE, 7'd31);
        add_item(KIND_REFERENCE, 7'd32);
        add_item(KIND_REFERENCE, 7'd127);
        add_item(KIND_REFERENCE, 7'd0);
        add_item(KIND_REFERENCE, 7'd1);
        add_item(KIND_REFERENCE, 7'd2);
        add_item(KIND_REFERENCE, 7'd3);
        add_item(KIND_REFERENCE, 7'd4);
        add_item(KIND_REFERENCE, 7'd0);
        add_item(KIND_REFERENCE, 7'd1);
        add_item(KIND_RESTART, 7'd127);
        add_item(KIND_REFERENCE, 7'd5);
        settle();

        // LRU keeps entries: a hit refreshes, the stale one goes
        write_reg(CFG_POLICY_MODE, 8'hFF);
        add_item(KIND_REFERENCE, 7'd6);
        add_item(KIND_REFERENCE, 7'd7);
        add_item(KIND_REFERENCE, 7'd6);
        add_item(KIND_REFERENCE, 7'd8);
        add_item(KIND_REFERENCE, 7'd9);
        add_item(KIND_REFERENCE, 7'd10);
        add_item(KIND_REFERENCE, 7'd7);
        add_item(KIND_REFERENCE, 7'd5);
        settle();

        // bad size settings: zero ways, too many ways, odd memory size
        write_reg(CFG_WAYS_IN_USE, 8'h00);
        add_item(KIND_REFERENCE, 7'd3);
        add_item(KIND_RESTART, 7'd0);
        add_item(KIND_REFERENCE, 7'd127);
        settle();
        write_reg(CFG_MEM_BLOCKS, MEMB_128);
        write_reg(CFG_WAYS_IN_USE, 8'd33);
        add_item(KIND_REFERENCE, 7'd100);
        settle();
        write_reg(CFG_UNUSED, 8'h00);
        write_reg(CFG_MEM_BLOCKS, 8'hFF);
        write_reg(CFG_WAYS_IN_USE, 8'd32);
        add_item(KIND_REFERENCE, 7'd1);
        settle();

        for (int p = 0; p < 12; p++)
        begin
            legal = (p % 4) != 3;
            steady_run = (p == 6);
            random_setup(legal);
            if (legal)
            begin
                queue_references(90);
                settle();
                write_reg(CFG_POLICY_MODE, 8'($urandom_range(255)));
                queue_references(90);
            end
            else
                queue_references(40);
            settle();
        end

        // unbroken run at the largest size, then one more reference and a restart
        steady_run = 1'b1;
        write_reg(CFG_MEM_BLOCKS, MEMB_128);
        write_reg(CFG_WAYS_IN_USE, 8'd32);
        write_reg(CFG_POLICY_MODE, 8'h00);
        add_item(KIND_RESTART, 7'd0);
        for (int i = 0; i < 40; i++)
            add_item(KIND_REFERENCE, 7'($urandom_range(31)));
        add_item(KIND_REFERENCE, 7'd99);
        add_item(KIND_RESTART, 7'd0);
        add_item(KIND_REFERENCE, 7'd0);
        settle();
        repeat (4) @(posedge clk);

        if (fail_count == 0 && due_outcomes.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/facr_pkg.sv
rtl/facr_cell.sv
rtl/fully_assoc_cache_replacement_core.sv
tb/fully_assoc_cache_replacement_core_test.sv
